/* sv/prm_pkg.sv */
package prm_pkg;

    // Register file geometry
    localparam int NUM_REGS    = 4;
    localparam int MAX_RESULTS = 4;
    localparam int LIVE_MAX    = (NUM_REGS < MAX_RESULTS) ? NUM_REGS : MAX_RESULTS;
    localparam int RIDX_W      = (NUM_REGS > 1) ? $clog2(NUM_REGS) : 1;
    localparam int BIDX_W      = (LIVE_MAX > 1) ? $clog2(LIVE_MAX) : 1;

    // Field widths
    localparam int OPC_W  = 7;
    localparam int DATA_W = 8;
    localparam int KIND_W = 2;
    localparam int CFG_W  = 3;

    localparam logic [DATA_W-1:0] CODE_BASE = DATA_W'(5);
    localparam logic [CFG_W-1:0]  CFG_RESET = CFG_W'(4);

    typedef enum logic [OPC_W-1:0] {
        OP_HALT = 7'd0,
        OP_ADD  = 7'd1,
        OP_SUB  = 7'd2,
        OP_LOAD = 7'd3,
        OP_DUMP = 7'd4
    } t_opcode;

    typedef enum logic [KIND_W-1:0] {
        KIND_VALUE = 2'd0,
        KIND_ERROR = 2'd1,
        KIND_HALT  = 2'd2
    } t_kind;

    // Result burst handed from execute to the output stage
    typedef struct packed {
        logic                             valid;
        t_kind                            kind;
        logic [BIDX_W-1:0]                last_idx;
        logic [LIVE_MAX-1:0][DATA_W-1:0]  vals;
    } t_burst;

endpackage

/* sv/prm_if.sv */
interface prm_in_if;
    logic       valid;
    logic       ready;
    logic [6:0] opcode;
    logic       predicated;
    logic [7:0] operand_a;
    logic [7:0] operand_b;

    modport source (output valid, output opcode, output predicated,
                    output operand_a, output operand_b, input ready);
    modport sink   (input valid, input opcode, input predicated,
                    input operand_a, input operand_b, output ready);
endinterface

interface prm_out_if;
    logic       valid;
    logic       ready;
    logic [1:0] kind;
    logic [7:0] value;
    logic       last;

    modport source (output valid, output kind, output value, output last, input ready);
    modport sink   (input valid, input kind, input value, input last, output ready);
endinterface

/* sv/prm_exec.sv */
module prm_exec
    import prm_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_we,
    input  logic [CFG_W-1:0]  i_cfg_wdata,
    input  logic              i_slot_free,
    prm_in_if.sink            i_item,
    output t_burst            o_burst
);

    logic [NUM_REGS-1:0][DATA_W-1:0] r_rf, n_rf;
    logic                            r_zero, n_zero;
    logic                            r_halted, n_halted;
    logic [CFG_W-1:0]                r_cfg;

    logic [CFG_W-1:0]   live;
    logic [DATA_W-1:0]  off_a, off_b, v;
    logic               ok_a, ok_b, accept, skip;
    logic [RIDX_W-1:0]  ia, ib;
    t_opcode            op;
    t_burst             burst;

    assign i_item.ready = i_slot_free;
    assign accept       = i_item.valid && i_item.ready;
    assign op           = t_opcode'(i_item.opcode);
    assign skip         = i_item.predicated && !r_zero;

    // Clamp the live register count to 1..LIVE_MAX
    always_comb begin
        if (r_cfg == '0) begin
            live = CFG_W'(1);
        end else if (r_cfg > CFG_W'(LIVE_MAX)) begin
            live = CFG_W'(LIVE_MAX);
        end else begin
            live = r_cfg;
        end
    end

    // Register code decode
    always_comb begin
        off_a = i_item.operand_a - CODE_BASE;
        off_b = i_item.operand_b - CODE_BASE;
        ok_a  = (i_item.operand_a >= CODE_BASE) && (off_a < DATA_W'(live));
        ok_b  = (i_item.operand_b >= CODE_BASE) && (off_b < DATA_W'(live));
        ia    = off_a[RIDX_W-1:0];
        ib    = off_b[RIDX_W-1:0];
    end

    // Instruction execute
    always_comb begin
        n_rf     = r_rf;
        n_zero   = r_zero;
        n_halted = r_halted;
        burst    = '0;
        v        = '0;
        if (accept && !r_halted) begin
            if (skip) begin
                n_zero = 1'b0;
            end else begin
                unique case (op) inside
                    OP_HALT: begin
                        n_halted    = 1'b1;
                        burst.valid = 1'b1;
                        burst.kind  = KIND_HALT;
                    end
                    OP_ADD, OP_SUB, OP_LOAD: begin
                        if (!ok_a || (op != OP_LOAD && !ok_b)) begin
                            n_halted    = 1'b1;
                            burst.valid = 1'b1;
                            burst.kind  = KIND_ERROR;
                        end else begin
                            if (op == OP_LOAD) begin
                                v = i_item.operand_b;
                            end else if (op == OP_ADD) begin
                                v = r_rf[ia] + r_rf[ib];
                            end else begin
                                v = r_rf[ia] - r_rf[ib];
                            end
                            n_rf[ia] = v;
                            n_zero   = (v == '0);
                        end
                    end
                    OP_DUMP: begin
                        burst.valid    = 1'b1;
                        burst.kind     = KIND_VALUE;
                        burst.last_idx = BIDX_W'(live - CFG_W'(1));
                        for (int j = 0; j < LIVE_MAX; j++) begin
                            burst.vals[j] = r_rf[j];
                        end
                    end
                    default: ;
                endcase
            end
        end
    end

    assign o_burst = burst;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rf     <= '0;
            r_zero   <= 1'b0;
            r_halted <= 1'b0;
            r_cfg    <= CFG_RESET;
        end else begin
            r_rf     <= n_rf;
            r_zero   <= n_zero;
            r_halted <= n_halted;
            if (i_cfg_we) begin
                r_cfg <= i_cfg_wdata;
            end
        end
    end

    // Halt is permanent and silent
    a_halt_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_halted |=> r_halted) else $error("halted state cleared");
    a_halt_silent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_halted |-> !burst.valid) else $error("result issued after halt");
    a_halt_frozen: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_halted |=> $stable(r_rf) && $stable(r_zero))
        else $error("state changed after halt");

endmodule

/* sv/prm_out.sv */
module prm_out
    import prm_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  t_burst   i_burst,
    output logic     o_slot_free,
    prm_out_if.source o_result
);

    logic                             r_valid;
    t_kind                            r_kind;
    logic [BIDX_W-1:0]                r_last, r_idx;
    logic [LIVE_MAX-1:0][DATA_W-1:0]  r_vals;
    logic                             beat_last, take;

    assign beat_last   = (r_idx == r_last);
    assign take        = r_valid && o_result.ready;
    // Slot frees once the final beat of the current burst is taken
    assign o_slot_free = !r_valid || (o_result.ready && beat_last);

    assign o_result.valid = r_valid;
    assign o_result.kind  = r_kind;
    assign o_result.value = (r_kind == KIND_VALUE) ? r_vals[r_idx] : '0;
    assign o_result.last  = beat_last;

    // Control: burst load and beat stepping
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_idx   <= '0;
        end else if (i_burst.valid) begin
            r_valid <= 1'b1;
            r_idx   <= '0;
        end else if (take) begin
            if (beat_last) begin
                r_valid <= 1'b0;
            end else begin
                r_idx <= r_idx + BIDX_W'(1);
            end
        end
    end

    // Payload snapshot
    always_ff @(posedge i_clk) begin
        if (i_burst.valid) begin
            r_kind <= i_burst.kind;
            r_last <= i_burst.last_idx;
            r_vals <= i_burst.vals;
        end
    end

    a_burst_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_burst.valid |=> r_valid && r_idx == '0) else $error("burst did not start");
    a_idx_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_valid |-> r_idx <= r_last) else $error("beat index past end");
    a_single_beat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_valid && r_kind != KIND_VALUE |-> r_last == '0)
        else $error("status result spans several beats");

endmodule

/* sv/predicated_register_machine_core.sv */
// Predicated register machine: one instruction per input transaction on a
// file of 8-bit registers (codes 5 and up) with a zero flag. An instruction
// is accepted every cycle while the output register is free or its final
// beat is being taken; add, subtract, load and no-op give no result, halt
// and register-code errors give one result, and a dump gives one result per
// register in use, so the input stalls behind a dump while the single output
// register drains one beat a cycle, or holds while o_result.ready is low.
// After a halt or code error every transaction is accepted and dropped.
// i_cfg_wdata sets the registers in use (1..4); write it only while idle.
module predicated_register_machine_core
    import prm_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_we,
    input  logic [CFG_W-1:0]  i_cfg_wdata,
    prm_in_if.sink            i_item,
    prm_out_if.source         o_result
);

    t_burst burst;
    logic   slot_free;

    prm_exec u_exec (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_slot_free (slot_free),
        .i_item      (i_item),
        .o_burst     (burst)
    );

    prm_out u_out (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_burst     (burst),
        .o_slot_free (slot_free),
        .o_result    (o_result)
    );

endmodule
